// ===== design/windowed_sensor_averager_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the windowed sensor averager
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_SENSOR_AVERAGER_CORE_ASSERT_SVH
`define WINDOWED_SENSOR_AVERAGER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("windowed sensor averager: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("windowed sensor averager: next-cycle check failed");

`endif

// ===== design/wsa_pkg.sv =====
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared widths, reset values and the lane control bundle.
// ----------------------------------------------------------------------------
package wsa_pkg;

	localparam int WINDOW_W    = 24;
	localparam int ELAPSED_W   = 25;
	localparam int READING_W   = 16;
	localparam int ID_W        = 8;
	localparam int OUT_SENSORS = 3;

	localparam logic [WINDOW_W-1:0]  WINDOW_RESET = 24'd50000;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 25'h1FF_FFFF;

	// Commands carried by an input transfer.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// Control from the sequencer to one lane.
	typedef struct packed {
		logic add;     // accumulate the current sample
		logic load;    // move sums into the dividers, clear the window
		logic step;    // one divider iteration
		logic finish;  // write quotients into the held averages
	} lane_ctrl_t;

endpackage

// ===== design/wsa_ifs.sv =====
// ----------------------------------------------------------------------------
// wsa_in_if / wsa_out_if
// Valid/ready channels for sensor items and for published averages.
// ----------------------------------------------------------------------------
interface wsa_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  cmd;
	logic        [wsa_pkg::ID_W-1:0]       sensor_id;
	logic signed [wsa_pkg::READING_W-1:0]  x_reading;
	logic signed [wsa_pkg::READING_W-1:0]  y_reading;

	modport source (output valid, cmd, sensor_id, x_reading, y_reading, input ready);
	modport sink (input valid, cmd, sensor_id, x_reading, y_reading, output ready);
endinterface

interface wsa_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [wsa_pkg::READING_W-1:0]  avg_s1_x;
	logic signed [wsa_pkg::READING_W-1:0]  avg_s1_y;
	logic signed [wsa_pkg::READING_W-1:0]  avg_s2_x;
	logic signed [wsa_pkg::READING_W-1:0]  avg_s2_y;
	logic signed [wsa_pkg::READING_W-1:0]  avg_s3_x;
	logic signed [wsa_pkg::READING_W-1:0]  avg_s3_y;

	modport source (output valid, avg_s1_x, avg_s1_y, avg_s2_x, avg_s2_y, avg_s3_x,
		avg_s3_y, input ready);
	modport sink (input valid, avg_s1_x, avg_s1_y, avg_s2_x, avg_s2_y, avg_s3_x,
		avg_s3_y, output ready);
endinterface

// ===== design/wsa_div.sv =====
// ----------------------------------------------------------------------------
// wsa_div
// Bit-serial restoring divider: signed sum over unsigned count, truncated
// toward zero, one quotient bit per step.
// ----------------------------------------------------------------------------
module wsa_div #(
	parameter int SUM_W      = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 load,
	input  logic                                 step,
	input  logic signed [SUM_W-1:0]              dividend,
	input  logic        [COUNT_BITS-1:0]         divisor,
	output logic signed [wsa_pkg::READING_W-1:0] quotient
);

	logic [SUM_W-1:0]      mag_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] den_q;
	logic                  neg_q;

	logic [SUM_W-1:0]      mag_in;
	logic [COUNT_BITS:0]   rem_sh;
	logic [COUNT_BITS:0]   rem_diff;
	logic                  fits;

	always_comb begin
		mag_in   = dividend[SUM_W-1] ? (~$unsigned(dividend) + SUM_W'(1)) : $unsigned(dividend);
		rem_sh   = {rem_q, mag_q[SUM_W-1]};
		rem_diff = rem_sh - {1'b0, den_q};
		fits     = rem_sh >= {1'b0, den_q};
	end

	// The quotient bits shift in behind the dividend bits as they leave.
	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= mag_in;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (step) begin
			mag_q <= {mag_q[SUM_W-2:0], fits};
			rem_q <= fits ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
		end
	end

	// The magnitude of an average never exceeds 32768, so the low bits suffice.
	assign quotient = neg_q ? -$signed(mag_q[wsa_pkg::READING_W-1:0])
		: $signed(mag_q[wsa_pkg::READING_W-1:0]);

endmodule

// ===== design/wsa_lane.sv =====
// ----------------------------------------------------------------------------
// wsa_lane
// One sensor: x and y accumulators, a saturating sample count, two serial
// dividers and the held averages.
// ----------------------------------------------------------------------------
module wsa_lane #(
	parameter int COUNT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  wsa_pkg::lane_ctrl_t                  ctrl,
	input  logic signed [wsa_pkg::READING_W-1:0] x_reading,
	input  logic signed [wsa_pkg::READING_W-1:0] y_reading,
	output logic signed [wsa_pkg::READING_W-1:0] avg_x,
	output logic signed [wsa_pkg::READING_W-1:0] avg_y
);

	localparam int RW    = wsa_pkg::READING_W;
	localparam int SUM_W = RW + COUNT_BITS;

	logic signed [SUM_W-1:0]      sum_x_q;
	logic signed [SUM_W-1:0]      sum_y_q;
	logic        [COUNT_BITS-1:0] count_q;
	logic                         has_q;
	logic signed [RW-1:0]         avg_x_q;
	logic signed [RW-1:0]         avg_y_q;
	logic signed [RW-1:0]         quot_x;
	logic signed [RW-1:0]         quot_y;
	logic                         full;

	assign full = &count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			count_q <= '0;
			has_q   <= 1'b0;
			avg_x_q <= '0;
			avg_y_q <= '0;
		end else begin
			if (ctrl.load) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				count_q <= '0;
				has_q   <= count_q != '0;
			end else if (ctrl.add && !full) begin
				sum_x_q <= sum_x_q + {{(SUM_W-RW){x_reading[RW-1]}}, x_reading};
				sum_y_q <= sum_y_q + {{(SUM_W-RW){y_reading[RW-1]}}, y_reading};
				count_q <= count_q + COUNT_BITS'(1);
			end
			// A sensor with no samples in the window keeps its last average.
			if (ctrl.finish && has_q) begin
				avg_x_q <= quot_x;
				avg_y_q <= quot_y;
			end
		end
	end

	wsa_div #(.SUM_W(SUM_W), .COUNT_BITS(COUNT_BITS)) u_div_x (
		.clk      (clk),
		.load     (ctrl.load),
		.step     (ctrl.step),
		.dividend (sum_x_q),
		.divisor  (count_q),
		.quotient (quot_x)
	);

	wsa_div #(.SUM_W(SUM_W), .COUNT_BITS(COUNT_BITS)) u_div_y (
		.clk      (clk),
		.load     (ctrl.load),
		.step     (ctrl.step),
		.dividend (sum_y_q),
		.divisor  (count_q),
		.quotient (quot_y)
	);

	assign avg_x = avg_x_q;
	assign avg_y = avg_y_q;

endmodule

// ===== design/wsa_merge.sv =====
// ----------------------------------------------------------------------------
// wsa_merge
// Gathers the held averages of the lanes into the output register.
// ----------------------------------------------------------------------------
module wsa_merge #(
	parameter int NUM_SENSORS = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic signed [wsa_pkg::READING_W-1:0] avg_x [NUM_SENSORS],
	input  logic signed [wsa_pkg::READING_W-1:0] avg_y [NUM_SENSORS],
	output logic                                 slot_free,
	wsa_out_if.source                            avg_out
);

	localparam int RW = wsa_pkg::READING_W;
	localparam int OS = wsa_pkg::OUT_SENSORS;

	logic signed [RW-1:0] pick_x [OS];
	logic signed [RW-1:0] pick_y [OS];
	logic signed [RW-1:0] out_x_q [OS];
	logic signed [RW-1:0] out_y_q [OS];
	logic                 valid_q;

	// Outputs for sensors that are not built read as zero.
	for (genvar k = 0; k < OS; k++) begin : g_pick
		if (k < NUM_SENSORS) begin : g_have
			assign pick_x[k] = avg_x[k];
			assign pick_y[k] = avg_y[k];
		end else begin : g_none
			assign pick_x[k] = '0;
			assign pick_y[k] = '0;
		end
	end

	assign slot_free = !valid_q || avg_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (avg_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_x_q <= pick_x;
			out_y_q <= pick_y;
		end
	end

	assign avg_out.valid    = valid_q;
	assign avg_out.avg_s1_x = out_x_q[0];
	assign avg_out.avg_s1_y = out_y_q[0];
	assign avg_out.avg_s2_x = out_x_q[1];
	assign avg_out.avg_s2_y = out_y_q[1];
	assign avg_out.avg_s3_x = out_x_q[2];
	assign avg_out.avg_s3_y = out_y_q[2];

endmodule

// ===== design/windowed_sensor_averager_core.sv =====
// ----------------------------------------------------------------------------
// windowed_sensor_averager_core
// Block-average decimator: per-sensor lanes accumulate samples and, when the
// tick window runs out, divide their sums and publish all held averages.
//
//   Channel     Direction  Transfer carries
//   sample_in   sink       cmd, sensor_id, x_reading, y_reading
//   avg_out     source     avg_s1_x .. avg_s3_y
//   cfg_we      write      cfg_wdata -> window_ticks
//
// A tick or a sample that does not close the window leaves the block ready for
// the next item. A sample that closes the window runs the load, divide, done and
// publish states: the lanes' bit-serial dividers step in the divide state, and
// publish waits for the output register to drain. Reset clears sums, counts,
// averages and the elapsed counter, and sets the window to 50000; no clearing
// pass follows. Ticks and samples are taken while a result waits on avg_out.
// ----------------------------------------------------------------------------
`include "windowed_sensor_averager_core_assert.svh"

module windowed_sensor_averager_core #(
	parameter int NUM_SENSORS = 3,
	parameter int COUNT_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wsa_pkg::WINDOW_W-1:0]  cfg_wdata,
	wsa_in_if.sink                        sample_in,
	wsa_out_if.source                     avg_out
);

	localparam int SUM_W  = wsa_pkg::READING_W + COUNT_BITS;
	localparam int STEP_W = $clog2(SUM_W);
	localparam int ID_W   = wsa_pkg::ID_W;
	localparam int RW     = wsa_pkg::READING_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_DONE = 5'b01000,
		ST_PUB  = 5'b10000
	} state_t;

	state_t                             state_q;
	state_t                             state_d;
	logic [STEP_W-1:0]                  step_cnt_q;
	logic [wsa_pkg::WINDOW_W-1:0]       window_q;
	logic [wsa_pkg::ELAPSED_W-1:0]      elapsed_q;
	logic                               accept;
	logic                               is_tick;
	logic                               window_up;
	logic                               slot_free;
	logic                               merge_load;
	wsa_pkg::lane_ctrl_t                lane_ctrl [NUM_SENSORS];
	logic signed [RW-1:0]               lane_avg_x [NUM_SENSORS];
	logic signed [RW-1:0]               lane_avg_y [NUM_SENSORS];

	assign sample_in.ready = state_q == ST_IDLE;
	assign accept          = sample_in.valid && sample_in.ready;
	assign is_tick         = sample_in.cmd == wsa_pkg::CMD_TICK;
	assign window_up       = elapsed_q > {1'b0, window_q};
	assign merge_load      = (state_q == ST_PUB) && slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && !is_tick && window_up) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV:  if (step_cnt_q == '0) state_d = ST_DONE;
			ST_DONE: state_d = ST_PUB;
			ST_PUB:  if (slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_cnt_q <= '0;
			window_q   <= wsa_pkg::WINDOW_RESET;
			elapsed_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD) begin
				step_cnt_q <= STEP_W'(SUM_W - 1);
			end else if (state_q == ST_DIV) begin
				step_cnt_q <= step_cnt_q - STEP_W'(1);
			end
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (accept && is_tick) begin
				if (elapsed_q != wsa_pkg::ELAPSED_MAX) begin
					elapsed_q <= elapsed_q + wsa_pkg::ELAPSED_W'(1);
				end
			end else if (accept && window_up) begin
				elapsed_q <= elapsed_q - {1'b0, window_q};
			end
		end
	end

	for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_lane
		assign lane_ctrl[i].add    = accept && !is_tick && (sample_in.sensor_id == ID_W'(i + 1));
		assign lane_ctrl[i].load   = state_q == ST_LOAD;
		assign lane_ctrl[i].step   = state_q == ST_DIV;
		assign lane_ctrl[i].finish = state_q == ST_DONE;

		wsa_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (lane_ctrl[i]),
			.x_reading (sample_in.x_reading),
			.y_reading (sample_in.y_reading),
			.avg_x     (lane_avg_x[i]),
			.avg_y     (lane_avg_y[i])
		);
	end

	wsa_merge #(.NUM_SENSORS(NUM_SENSORS)) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (merge_load),
		.avg_x     (lane_avg_x),
		.avg_y     (lane_avg_y),
		.slot_free (slot_free),
		.avg_out   (avg_out)
	);

	`WSA_ASSERT_NEXT(a_close_starts_load, clk, arst_n, accept && !is_tick && window_up, state_q == ST_LOAD)
	`WSA_ASSERT_NEXT(a_tick_stays_idle, clk, arst_n, accept && is_tick, state_q == ST_IDLE)
	`WSA_ASSERT_NEXT(a_load_arms_divider, clk, arst_n, state_q == ST_LOAD, (state_q == ST_DIV) && (step_cnt_q == STEP_W'(SUM_W - 1)))
	`WSA_ASSERT_SAME(a_result_from_publish, clk, arst_n, $rose(avg_out.valid), $past(state_q) == ST_PUB)

endmodule

// ===== bench/window_avg_checker.sv =====
// ----------------------------------------------------------------------------
// window_avg_checker
// Watches the configuration port and both channels of the averager and
// predicts every published set of averages from the accepted sensor items.
// Each accepted result is compared with the oldest prediction. Failures are
// counted and handed to the testbench top, along with the number of
// predictions still waiting.
// ----------------------------------------------------------------------------
module window_avg_checker
	import wsa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [WINDOW_W-1:0]  cfg_wdata,
	wsa_in_if                    sample_mon,
	wsa_out_if                   avg_mon,
	output int                   fail_count,
	output int                   pending
);

	localparam int               SENSORS   = 3;
	localparam logic [15:0]      COUNT_MAX = 16'hFFFF;
	localparam int               SHOW_MAX  = 10;

	typedef struct packed {
		logic signed [READING_W-1:0] s1_x;
		logic signed [READING_W-1:0] s1_y;
		logic signed [READING_W-1:0] s2_x;
		logic signed [READING_W-1:0] s2_y;
		logic signed [READING_W-1:0] s3_x;
		logic signed [READING_W-1:0] s3_y;
	} avg_set_t;

	logic [WINDOW_W-1:0]          window_len;
	logic [ELAPSED_W-1:0]         elapsed;
	logic signed [31:0]           sums [2*SENSORS];
	logic [15:0]                  counts [SENSORS];
	logic signed [READING_W-1:0]  held [2*SENSORS];
	avg_set_t                     expected_avgs [$];
	avg_set_t                     seen;
	avg_set_t                     want;

	task automatic report(input string msg);
		fail_count++;
		if (fail_count <= SHOW_MAX)
			$display("%s", msg);
	endtask

	// Updates the predicted state with one accepted item and queues the
	// published averages if the item closes the window.
	task automatic absorb_item(input logic cmd, input logic [ID_W-1:0] id,
			input logic signed [READING_W-1:0] xr, input logic signed [READING_W-1:0] yr);
		int s;
		avg_set_t res;
		if (cmd == CMD_TICK) begin
			if (elapsed != ELAPSED_MAX)
				elapsed++;
			return;
		end
		if (id >= 1 && id <= SENSORS) begin
			s = id - 1;
			if (counts[s] != COUNT_MAX) begin
				sums[2*s]   = sums[2*s] + xr;
				sums[2*s+1] = sums[2*s+1] + yr;
				counts[s]++;
			end
		end
		if (elapsed <= {1'b0, window_len})
			return;
		elapsed = elapsed - {1'b0, window_len};
		for (s = 0; s < SENSORS; s++) begin
			// Signed division truncates toward zero, as the averages require.
			if (counts[s] != 0) begin
				held[2*s]   = 16'(sums[2*s] / $signed({16'd0, counts[s]}));
				held[2*s+1] = 16'(sums[2*s+1] / $signed({16'd0, counts[s]}));
			end
			counts[s]   = '0;
			sums[2*s]   = '0;
			sums[2*s+1] = '0;
		end
		res.s1_x = held[0];
		res.s1_y = held[1];
		res.s2_x = held[2];
		res.s2_y = held[3];
		res.s3_x = held[4];
		res.s3_y = held[5];
		expected_avgs.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len = WINDOW_RESET;
			elapsed    = '0;
			for (int i = 0; i < 2*SENSORS; i++) begin
				sums[i] = '0;
				held[i] = '0;
			end
			for (int i = 0; i < SENSORS; i++)
				counts[i] = '0;
			expected_avgs.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_we)
				window_len = cfg_wdata;
			if (avg_mon.valid && avg_mon.ready) begin
				seen.s1_x = avg_mon.avg_s1_x;
				seen.s1_y = avg_mon.avg_s1_y;
				seen.s2_x = avg_mon.avg_s2_x;
				seen.s2_y = avg_mon.avg_s2_y;
				seen.s3_x = avg_mon.avg_s3_x;
				seen.s3_y = avg_mon.avg_s3_y;
				if (expected_avgs.size() == 0) begin
					report($sformatf("unexpected averages %0d %0d %0d %0d %0d %0d",
						seen.s1_x, seen.s1_y, seen.s2_x, seen.s2_y, seen.s3_x, seen.s3_y));
				end else begin
					want = expected_avgs.pop_front();
					if (seen !== want)
						report($sformatf({"averages mismatch: expected %0d %0d %0d %0d %0d %0d",
							" got %0d %0d %0d %0d %0d %0d"},
							want.s1_x, want.s1_y, want.s2_x, want.s2_y, want.s3_x, want.s3_y,
							seen.s1_x, seen.s1_y, seen.s2_x, seen.s2_y, seen.s3_x, seen.s3_y));
				end
			end
			if (sample_mon.valid && sample_mon.ready)
				absorb_item(sample_mon.cmd, sample_mon.sensor_id, sample_mon.x_reading,
					sample_mon.y_reading);
			pending = expected_avgs.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the windowed sensor averager. Drives directed and random
// ticks and samples through several window settings, including one,
// zero and the largest.
// Both channels idle at random; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
	import wsa_pkg::*;

	localparam int                  CYCLE_LIMIT   = 1_000_000;
	localparam int                  DRAIN_CYCLES  = 60;
	localparam int                  RANDOM_PHASES = 5;
	localparam int                  PHASE_ITEMS   = 100;
	localparam int                  LARGE_SAMPLES = 20;
	localparam logic [WINDOW_W-1:0] WINDOW_MAX    = '1;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [WINDOW_W-1:0]  cfg_wdata;
	int                   fail_count;
	int                   pending;
	int unsigned          cycle_count = 0;
	int                   in_gap = 0;
	bit                   calm = 1'b0;

	wsa_in_if  sample_in ();
	wsa_out_if avg_out ();

	windowed_sensor_averager_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample_in (sample_in),
		.avg_out   (avg_out)
	);

	window_avg_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.sample_mon (sample_in),
		.avg_mon    (avg_out),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic logic signed [READING_W-1:0] pick_reading();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [ID_W-1:0] pick_sensor();
		if ($urandom_range(0, 99) < 85)
			return 8'($urandom_range(1, OUT_SENSORS));
		return 8'($urandom);
	endfunction

	// Valid stays high across back-to-back transfers; here it only drops when a
	// gap was drawn for the next item (set_window and the end also drop it).
	task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
			input logic signed [READING_W-1:0] xr, input logic signed [READING_W-1:0] yr);
		if (in_gap > 0) begin
			sample_in.valid <= 1'b0;
			repeat (in_gap) @(posedge clk);
		end
		sample_in.valid     <= 1'b1;
		sample_in.cmd       <= cmd;
		sample_in.sensor_id <= id;
		sample_in.x_reading <= xr;
		sample_in.y_reading <= yr;
		@(posedge clk);
		while (!sample_in.ready) @(posedge clk);
		in_gap = draw_wait();
	endtask

	task automatic send_tick();
		send_item(CMD_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// The window may only change while the block is idle. Once the last
	// predicted result has been taken the block is idle; a short pause follows.
	task automatic set_window(input logic [WINDOW_W-1:0] ticks);
		sample_in.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int stall;
		avg_out.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				avg_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			avg_out.ready <= 1'b1;
			@(posedge clk);
			while (!avg_out.valid) @(posedge clk);
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[windowed_sensor_averager_core] ERROR");
		$finish;
	end

	initial begin
		int                   tick_pct;
		logic [WINDOW_W-1:0]  win;

		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= '0;
		sample_in.valid     <= 1'b0;
		sample_in.cmd       <= CMD_SAMPLE;
		sample_in.sensor_id <= '0;
		sample_in.x_reading <= '0;
		sample_in.y_reading <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reading extremes, ignored sensor numbers, truncation
		// toward zero and sensors that keep their last average.
		set_window(WINDOW_W'(1));
		send_item(CMD_SAMPLE, 8'd1, 16'sh7FFF, 16'sh8000);
		send_item(CMD_SAMPLE, 8'd2, 16'sh8000, 16'sh7FFF);
		send_item(CMD_SAMPLE, 8'd3, -16'sd1, 16'sd1);
		send_item(CMD_SAMPLE, 8'd0, 16'sd1234, -16'sd1234);
		send_item(CMD_SAMPLE, 8'd255, 16'sh8000, 16'sh8000);
		send_item(CMD_SAMPLE, 8'd4, 16'sd7, 16'sd7);
		send_tick();
		send_tick();
		send_item(CMD_SAMPLE, 8'd1, -16'sd3, 16'sd5);
		send_item(CMD_SAMPLE, 8'd3, -16'sd1, 16'sd3);
		send_item(CMD_SAMPLE, 8'd3, -16'sd2, 16'sd0);
		send_tick();
		send_item(CMD_SAMPLE, 8'd170, 16'sh5555, 16'shAAAA);

		// A zero window publishes on every sample once ticks have counted.
		set_window('0);
		send_item(CMD_SAMPLE, 8'd85, 16'shAAAA, 16'sh5555);
		send_item(CMD_SAMPLE, 8'd2, 16'sh7FFF, 16'sh7FFF);
		send_tick();
		send_item(CMD_SAMPLE, 8'd3, 16'sh8000, 16'sh0001);

		// Accumulate under the largest window, then close it with a short one.
		set_window(WINDOW_MAX);
		send_item(CMD_SAMPLE, 8'd1, pick_reading(), pick_reading());
		repeat (LARGE_SAMPLES) send_item(CMD_SAMPLE, 8'd2, pick_reading(), pick_reading());
		set_window(WINDOW_W'(1));
		send_tick();
		send_tick();
		send_item(CMD_SAMPLE, 8'd2, 16'sh8000, 16'sh8000);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: win = WINDOW_W'($urandom_range(1, 6));
				1: win = '0;
				2: win = WINDOW_W'($urandom_range(7, 40));
				3: win = WINDOW_W'(1);
				default: win = WINDOW_W'($urandom_range(2, 12));
			endcase
			set_window(win);
			calm     = (p == 3);
			tick_pct = $urandom_range(20, 70);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < tick_pct)
					send_tick();
				else
					send_item(CMD_SAMPLE, pick_sensor(), pick_reading(), pick_reading());
			end
		end
		calm = 1'b0;

		sample_in.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[windowed_sensor_averager_core] OK");
		else
			$display("[windowed_sensor_averager_core] ERROR");
		$finish;
	end

endmodule

// ===== windowed_sensor_averager_core.f =====
+incdir+design
design/wsa_pkg.sv
design/wsa_ifs.sv
design/wsa_div.sv
design/wsa_lane.sv
design/wsa_merge.sv
design/windowed_sensor_averager_core.sv
bench/window_avg_checker.sv
bench/tb_top.sv
